### hdl/mhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhs_pkg
// Shared types, codes and the FNV-1 step for the MinHash signature unit.
// ----------------------------------------------------------------------------
package mhs_pkg;

    // request codes
    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SEED_ONE = 2'd0;
    localparam logic [1:0] CFG_SEED_TWO = 2'd1;
    localparam logic [1:0] CFG_ACTIVE   = 2'd2;

    // reset values and hash constants
    localparam logic [63:0] SEED_ONE_RST = 64'd3440579354231278675;
    localparam logic [63:0] SEED_TWO_RST = 64'd608747136543856411;
    localparam logic [7:0]  ACTIVE_RST   = 8'd128;
    localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
    localparam logic [63:0] ALL_ONES     = {64{1'b1}};

    // input beat
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [6:0] entry_index;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [63:0] min_value;
        logic [6:0]  read_index;
    } t_out_beat;

    // seed engine status towards the top level
    typedef struct packed {
        logic        busy;
        logic [63:0] start_one;
        logic [63:0] start_two;
    } t_seed_status;

    // one FNV-1 step: multiply by the 64-bit prime (2^40 + 0x1B3), then xor
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] p;
        p = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
        return p ^ {56'd0, b};
    endfunction

endpackage

### hdl/minhash_signature_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minhash_signature_update_unit
// MinHash signature builder: two seeded FNV-1 64-bit hashes per element,
// double hashing into a memory of per-entry minimums.
// ----------------------------------------------------------------------------
// An element byte that is not the last updates only the running hashes, and
// bytes may follow back to back. A last byte walks the first
// min(active_hashes, NUM_HASH) entries and then drains the write-back, or
// walks none when no entry is active: the signature memory is walked one
// entry a cycle through its single read port and write-back. A read passes
// through the memory read, then the output register; a clear sweeps the
// memory one entry a cycle, and after reset the same clearing pass runs
// before any item is taken. Each configuration write restarts the seed
// absorption, during which no item is taken; configuration beats are always taken.
// ----------------------------------------------------------------------------
module minhash_signature_update_unit #(
    parameter int NUM_HASH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mhs_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mhs_pkg::t_out_beat o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    localparam int AW  = (NUM_HASH > 1) ? $clog2(NUM_HASH) : 1;
    localparam int CW0 = $clog2(NUM_HASH + 1);
    localparam int CW  = (CW0 > 8) ? CW0 : 8;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_CLEAR = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;

    // configuration registers
    logic [63:0] r_seed_one;
    logic [63:0] r_seed_two;
    logic [7:0]  r_active;
    logic [63:0] n_seed_one;
    logic [63:0] n_seed_two;
    logic [7:0]  n_active;
    logic        w_cfg_acc;

    mhs_pkg::t_seed_status w_seed;

    // control
    logic [2:0]    r_state;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_last_addr;
    logic          r_mid;
    logic          r_pend;
    logic          r_out_valid;

    // datapath
    logic [63:0]   r_h_one;
    logic [63:0]   r_h_two;
    logic [63:0]   r_hv;
    logic [63:0]   r_v2;
    logic [AW-1:0] r_pend_addr;
    logic [63:0]   r_pend_hv;
    logic [63:0]   r_rdata;
    logic [6:0]    r_rd_idx;
    logic          r_rd_oor;
    mhs_pkg::t_out_beat r_out;

    logic [63:0] mem [NUM_HASH];

    logic          w_in_acc;
    logic [63:0]   w_h_one;
    logic [63:0]   w_h_two;
    logic [CW-1:0] w_act_ext;
    logic [CW-1:0] w_count;
    logic [AW-1:0] w_last;
    logic [AW+6:0] w_idx_ext;
    logic [AW-1:0] w_in_addr;
    logic          w_in_oor;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [63:0]   w_wdata;
    logic [AW-1:0] w_raddr;

    // configuration port
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid;

    always_comb begin
        n_seed_one = r_seed_one;
        n_seed_two = r_seed_two;
        n_active   = r_active;
        if (w_cfg_acc) begin
            unique case (i_cfg_index)
                mhs_pkg::CFG_SEED_ONE: n_seed_one = i_cfg_data;
                mhs_pkg::CFG_SEED_TWO: n_seed_two = i_cfg_data;
                mhs_pkg::CFG_ACTIVE:   n_active   = i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_one <= mhs_pkg::SEED_ONE_RST;
            r_seed_two <= mhs_pkg::SEED_TWO_RST;
            r_active   <= mhs_pkg::ACTIVE_RST;
        end else begin
            r_seed_one <= n_seed_one;
            r_seed_two <= n_seed_two;
            r_active   <= n_active;
        end
    end

    mhs_seeder u_seeder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_cfg_acc),
        .i_seed_one (n_seed_one),
        .i_seed_two (n_seed_two),
        .o_status   (w_seed)
    );

    // input handshake; a read waits until the output register can take it
    assign o_in_ready = (r_state == ST_IDLE) && !w_seed.busy &&
                        !((i_in.req_type == mhs_pkg::REQ_READ) && r_out_valid && !i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // running hashes: a fresh element starts from the seeded values
    assign w_h_one = mhs_pkg::fnv_step(r_mid ? r_h_one : w_seed.start_one, i_in.data_byte);
    assign w_h_two = mhs_pkg::fnv_step(r_mid ? r_h_two : w_seed.start_two, i_in.data_byte);

    // entries to walk, saturated to the memory depth
    assign w_act_ext = CW'(r_active);
    assign w_count   = (w_act_ext > CW'(NUM_HASH)) ? CW'(NUM_HASH) : w_act_ext;
    assign w_last    = AW'(w_count - CW'(1));

    // read address and range check
    assign w_idx_ext = {{AW{1'b0}}, i_in.entry_index};
    assign w_in_addr = w_idx_ext[AW-1:0];
    assign w_in_oor  = (32'(i_in.entry_index) >= NUM_HASH);

    // control state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_mid       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= (r_state == ST_WALK);
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in.req_type)
                            mhs_pkg::REQ_BYTE: begin
                                r_mid <= !i_in.last_byte;
                                r_addr <= '0;
                                if (i_in.last_byte && (w_count != '0)) begin
                                    r_state <= ST_WALK;
                                end
                            end
                            mhs_pkg::REQ_READ:  r_state <= ST_READ;
                            mhs_pkg::REQ_CLEAR: begin
                                r_addr  <= '0;
                                r_state <= ST_CLEAR;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WALK: begin
                    if (r_addr == r_last_addr) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                ST_DRAIN: r_state <= ST_IDLE;
                ST_CLEAR: begin
                    if (r_addr == AW'(NUM_HASH - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                ST_READ: begin
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.req_type == mhs_pkg::REQ_BYTE)) begin
            r_h_one     <= w_h_one;
            r_h_two     <= w_h_two;
            r_hv        <= w_h_one;
            r_v2        <= w_h_two;
            r_last_addr <= w_last;
        end else if (r_state == ST_WALK) begin
            r_hv <= r_hv + r_v2;
        end
        if (w_in_acc && (i_in.req_type == mhs_pkg::REQ_READ)) begin
            r_rd_idx <= i_in.entry_index;
            r_rd_oor <= w_in_oor;
        end
        // write-back stage tracks the read issued in the previous cycle
        r_pend_addr <= r_addr;
        r_pend_hv   <= r_hv;
        if (r_state == ST_READ) begin
            r_out.min_value  <= r_rd_oor ? mhs_pkg::ALL_ONES : r_rdata;
            r_out.read_index <= r_rd_idx;
        end
    end

    // memory port selection: clear sweep or compare write-back
    assign w_we    = (r_state == ST_CLEAR) || (r_pend && (r_pend_hv < r_rdata));
    assign w_waddr = (r_state == ST_CLEAR) ? r_addr : r_pend_addr;
    assign w_wdata = (r_state == ST_CLEAR) ? mhs_pkg::ALL_ONES : r_pend_hv;
    assign w_raddr = (r_state == ST_WALK) ? r_addr : w_in_addr;

    // signature memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    // a result only appears after a read has gone through the memory
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_READ))
        else $error("result beat without a memory read");

    // write-back is only pending right after a walk step
    a_pend_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_state == ST_WALK))
        else $error("write-back pending outside a walk");

    // the walk stays within the active entries
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_addr <= r_last_addr))
        else $error("walk address past last active entry");
`endif

endmodule

### hdl/mhs_seeder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhs_seeder
// Absorbs both 64-bit seeds big-endian into the FNV offset basis, one byte a
// cycle, giving the start values of the two running hashes.
// ----------------------------------------------------------------------------
module mhs_seeder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [63:0]           i_seed_one,
    input  logic [63:0]           i_seed_two,
    output mhs_pkg::t_seed_status o_status
);

    logic        r_busy;
    logic [2:0]  r_cnt;
    logic [63:0] r_sd_one;
    logic [63:0] r_sd_two;
    logic [63:0] r_sh_one;
    logic [63:0] r_sh_two;

    // byte-serial seed absorption; a new load restarts the pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_cnt    <= 3'd0;
            r_sd_one <= mhs_pkg::FNV_BASIS;
            r_sd_two <= mhs_pkg::FNV_BASIS;
            r_sh_one <= mhs_pkg::SEED_ONE_RST;
            r_sh_two <= mhs_pkg::SEED_TWO_RST;
        end else if (i_load) begin
            r_busy   <= 1'b1;
            r_cnt    <= 3'd0;
            r_sd_one <= mhs_pkg::FNV_BASIS;
            r_sd_two <= mhs_pkg::FNV_BASIS;
            r_sh_one <= i_seed_one;
            r_sh_two <= i_seed_two;
        end else if (r_busy) begin
            r_sd_one <= mhs_pkg::fnv_step(r_sd_one, r_sh_one[63:56]);
            r_sd_two <= mhs_pkg::fnv_step(r_sd_two, r_sh_two[63:56]);
            r_sh_one <= r_sh_one << 8;
            r_sh_two <= r_sh_two << 8;
            r_cnt    <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_status.busy      = r_busy;
    assign o_status.start_one = r_sd_one;
    assign o_status.start_two = r_sd_two;

endmodule

### test/minhash_signature_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minhash_signature_check
// Watches the request, result and register channels of the MinHash
// signature unit. It keeps its own copy of the seeds, the running hashes and
// the per-entry minimums, and works out the expected beat for every read.
// Each result beat is compared against the oldest read still outstanding.
// ----------------------------------------------------------------------------
module minhash_signature_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  mhs_pkg::t_in_beat  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  mhs_pkg::t_out_beat i_out,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output int                 o_pending,
    output int                 o_fail_count
);
    import mhs_pkg::*;

    localparam int          SIG_ENTRIES   = 128;
    localparam logic [63:0] OFFSET_BASIS  = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME_64  = 64'd1099511628211;
    localparam logic [63:0] SEED_ONE_INIT = 64'd3440579354231278675;
    localparam logic [63:0] SEED_TWO_INIT = 64'd608747136543856411;
    localparam logic [7:0]  ACTIVE_INIT   = 8'd128;

    // predicted block state
    logic [63:0] seed_a;
    logic [63:0] seed_b;
    logic [7:0]  active_cnt;
    logic [63:0] hash_a;
    logic [63:0] hash_b;
    logic        in_element;
    logic [63:0] sig_min [SIG_ENTRIES];
    t_out_beat   read_results [$];
    int          mismatches;

    // FNV-1: multiply first, then fold the byte in
    function automatic logic [63:0] hash_byte(input logic [63:0] h, input logic [7:0] b);
        return (h * FNV_PRIME_64) ^ {56'd0, b};
    endfunction

    // basis with the seed absorbed most significant byte first
    function automatic logic [63:0] seed_prefixed_basis(input logic [63:0] seed);
        logic [63:0] h;
        h = OFFSET_BASIS;
        for (int k = 7; k >= 0; k--) begin
            h = hash_byte(h, seed[k*8 +: 8]);
        end
        return h;
    endfunction

    always @(posedge i_clk) begin : p_track
        t_out_beat   want;
        int          walk_len;
        logic [63:0] cand;
        if (!i_rst_n) begin
            seed_a     = SEED_ONE_INIT;
            seed_b     = SEED_TWO_INIT;
            active_cnt = ACTIVE_INIT;
            hash_a     = seed_prefixed_basis(SEED_ONE_INIT);
            hash_b     = seed_prefixed_basis(SEED_TWO_INIT);
            in_element = 1'b0;
            for (int i = 0; i < SIG_ENTRIES; i++) begin
                sig_min[i] = '1;
            end
            read_results.delete();
            mismatches = 0;
        end else begin
            // result beats: compare against the oldest outstanding read
            if (i_out_valid && i_out_ready) begin
                if (read_results.size() == 0) begin
                    $error("min_value: no read outstanding, actual %h (read_index %0d)",
                           i_out.min_value, i_out.read_index);
                    mismatches++;
                end else begin
                    want = read_results.pop_front();
                    if (i_out.min_value !== want.min_value) begin
                        $error("min_value: expected %h, actual %h",
                               want.min_value, i_out.min_value);
                        mismatches++;
                    end
                    if (i_out.read_index !== want.read_index) begin
                        $error("read_index: expected %0d, actual %0d",
                               want.read_index, i_out.read_index);
                        mismatches++;
                    end
                end
            end

            // register beats; an open element keeps the seeds it began with
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SEED_ONE: seed_a = i_cfg_data;
                    CFG_SEED_TWO: seed_b = i_cfg_data;
                    CFG_ACTIVE:   active_cnt = i_cfg_data[7:0];
                    default:      ;
                endcase
                if (!in_element) begin
                    hash_a = seed_prefixed_basis(seed_a);
                    hash_b = seed_prefixed_basis(seed_b);
                end
            end

            // request beats
            if (i_in_valid && i_in_ready) begin
                case (i_in.req_type)
                    REQ_BYTE: begin
                        hash_a     = hash_byte(hash_a, i_in.data_byte);
                        hash_b     = hash_byte(hash_b, i_in.data_byte);
                        in_element = 1'b1;
                        if (i_in.last_byte) begin
                            // double hashing; counts above the store size saturate
                            walk_len = (active_cnt > SIG_ENTRIES) ? SIG_ENTRIES : active_cnt;
                            for (int i = 0; i < walk_len; i++) begin
                                cand = hash_a + hash_b * 64'(i);
                                if (cand < sig_min[i]) begin
                                    sig_min[i] = cand;
                                end
                            end
                            hash_a     = seed_prefixed_basis(seed_a);
                            hash_b     = seed_prefixed_basis(seed_b);
                            in_element = 1'b0;
                        end
                    end
                    REQ_READ: begin
                        want.min_value  = (int'(i_in.entry_index) < SIG_ENTRIES) ?
                                          sig_min[i_in.entry_index] : '1;
                        want.read_index = i_in.entry_index;
                        read_results.push_back(want);
                    end
                    REQ_CLEAR: begin
                        for (int i = 0; i < SIG_ENTRIES; i++) begin
                            sig_min[i] = '1;
                        end
                    end
                    default: ; // unknown request: dropped without a result
                endcase
            end
        end
        o_pending    <= read_results.size();
        o_fail_count <= mismatches;
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the MinHash signature unit: a directed opening (reset state,
// byte extremes, unknown request, read and clear inside an element), then
// phases of random elements, reads and clears under changing seeds and
// entry counts, with random idling on both channels and a long output stall.
// Checking is done by minhash_signature_check alongside the block.
// ----------------------------------------------------------------------------
module tb;
    import mhs_pkg::*;

    localparam int         RESET_CYCLES = 6;
    localparam int         MAX_CYCLES   = 1_000_000;
    localparam int         DRAIN_CYCLES = 160;   // longer than a full walk or clear
    localparam int         LONG_HOLD    = 400;
    localparam int         PHASES       = 8;
    localparam int         PHASE_ITEMS  = 60;
    localparam logic [1:0] REQ_UNKNOWN  = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_beat    in_beat;
    logic        out_valid;
    logic        out_ready;
    t_out_beat   out_beat;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    logic        quiet;        // no idling on either side
    logic        hold_req;     // ask the sink for one long stall
    int          pending;
    int          fail_count;
    int          elem_len;
    int          elem_target;
    int unsigned cycle_count = 0;

    minhash_signature_update_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    minhash_signature_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 20 ns clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result sink: random stalls, one long hold on request
    initial begin : p_sink
        logic hold_served;
        hold_served = 1'b0;
        out_ready   = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    function automatic t_in_beat make_beat(input logic [1:0] req, input logic [7:0] data,
                                           input logic last, input logic [6:0] idx);
        t_in_beat b;
        b.req_type    = req;
        b.data_byte   = data;
        b.last_byte   = last;
        b.entry_index = idx;
        return b;
    endfunction

    // offer one beat, possibly after an idle burst; valid stays up on return
    task automatic send_beat(input t_in_beat b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    // wait for every read to come back, then let any walk or clear finish
    task automatic drain_block();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_settings(input logic [2:0] mask, input logic [63:0] s1,
                                  input logic [63:0] s2, input logic [7:0] act);
        if (mask[0]) write_reg(CFG_SEED_ONE, s1);
        if (mask[1]) write_reg(CFG_SEED_TWO, s2);
        if (mask[2]) write_reg(CFG_ACTIVE, {56'd0, act});
        if (mask != 3'b000) cfg_valid <= 1'b0;
    endtask

    // mostly well-formed elements, interleaved with reads, clears and noise
    task automatic random_items(input int count);
        int       r;
        t_in_beat b;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 58) begin
                if (elem_target == 0) begin
                    elem_target = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                               : $urandom_range(1, 4);
                end
                elem_len++;
                b = make_beat(REQ_BYTE, 8'($urandom_range(0, 255)), elem_len >= elem_target,
                              7'($urandom_range(0, 127)));
                if (elem_len >= elem_target) begin
                    elem_len    = 0;
                    elem_target = 0;
                end
            end else if (r < 90) begin
                b = make_beat(REQ_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              7'($urandom_range(0, 127)));
            end else if (r < 94) begin
                b = make_beat(REQ_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              7'($urandom_range(0, 127)));
            end else begin
                b = make_beat(REQ_UNKNOWN, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
            end
            send_beat(b);
        end
    endtask

    initial begin : p_stim
        logic [7:0] act;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_beat     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_SEED_ONE;
        cfg_data    = '0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        elem_len    = 0;
        elem_target = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset contents, unknown request, byte extremes
        send_beat(make_beat(REQ_READ,    8'h00, 1'b0, 7'd0));
        send_beat(make_beat(REQ_READ,    8'hFF, 1'b1, 7'd127));
        send_beat(make_beat(REQ_UNKNOWN, 8'hFF, 1'b1, 7'h7F));
        send_beat(make_beat(REQ_BYTE,    8'h00, 1'b0, 7'h7F));
        send_beat(make_beat(REQ_BYTE,    8'hFF, 1'b1, 7'h7F));
        send_beat(make_beat(REQ_READ,    8'hFF, 1'b1, 7'd0));
        send_beat(make_beat(REQ_READ,    8'h00, 1'b0, 7'd127));
        send_beat(make_beat(REQ_READ,    8'h00, 1'b0, 7'd64));
        // read and clear inside an open element
        send_beat(make_beat(REQ_BYTE,    8'hA5, 1'b0, 7'd0));
        send_beat(make_beat(REQ_READ,    8'h00, 1'b0, 7'd1));
        send_beat(make_beat(REQ_CLEAR,   8'hFF, 1'b1, 7'h7F));
        send_beat(make_beat(REQ_READ,    8'h00, 1'b1, 7'd1));
        send_beat(make_beat(REQ_BYTE,    8'h5A, 1'b1, 7'd0));
        send_beat(make_beat(REQ_READ,    8'h00, 1'b0, 7'd1));
        send_beat(make_beat(REQ_READ,    8'h00, 1'b0, 7'd126));
        // single-byte element
        send_beat(make_beat(REQ_BYTE,    8'h80, 1'b1, 7'd0));
        send_beat(make_beat(REQ_READ,    8'h00, 1'b0, 7'd0));
        // leave an element open across the first seed change
        send_beat(make_beat(REQ_BYTE,    8'h3C, 1'b0, 7'd0));
        elem_len    = 1;
        elem_target = 3;
        drain_block();

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       act = 8'd2;
                1:       act = 8'd64;
                2:       act = 8'd127;
                default: act = 8'($urandom_range(0, 255));
            endcase
            // extremes first, then random subsets of the registers
            case (ph)
                0:       write_settings(3'b111, 64'd0, '1, 8'd0);
                1:       write_settings(3'b111, '1, 64'd0, 8'd1);
                2:       write_settings(3'b100, 64'd0, 64'd0, 8'd255);
                3:       write_settings(3'b111, {$urandom, $urandom}, {$urandom, $urandom},
                                        8'd128);
                4:       write_settings(3'b100, 64'd0, 64'd0, 8'd129);
                default: write_settings(3'($urandom_range(1, 7)), {$urandom, $urandom},
                                        {$urandom, $urandom}, act);
            endcase
            if (ph == PHASES - 1) quiet <= 1'b1;
            // long output stall while reads keep coming, so the input backs up
            if (ph == 3) begin
                hold_req <= 1'b1;
                repeat (30) begin
                    send_beat(make_beat(REQ_READ, 8'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1)),
                                        7'($urandom_range(0, 127))));
                end
            end
            random_items(PHASE_ITEMS);
            drain_block();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/mhs_pkg.sv
hdl/mhs_seeder.sv
hdl/minhash_signature_update_unit.sv
test/minhash_signature_check.sv
test/tb.sv
